[src/swc_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the segment/wall crossing test.
// No dependencies; every other file of the block imports this package.
package swc_pkg;

    localparam int MAX_WALLS = 64;
    localparam int AW        = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CNT_W     = $clog2(MAX_WALLS + 1);
    localparam int COORD_W   = 16;
    localparam int ENTRY_W   = 4 * COORD_W;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int COUNT_W   = 7;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic          start;
        logic          wr_en;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
        logic          load_result;
    } swc_cmd_t;

    typedef struct packed {
        logic busy;
    } swc_status_t;

    // True when n/d lies in [0,1]; a zero determinant never passes.
    function automatic logic in_unit(input logic signed [SUM_W-1:0] n,
                                     input logic signed [SUM_W-1:0] d);
        logic res;
        begin
            if (d > 0) begin
                res = (n >= 0) && (n <= d);
            end else if (d < 0) begin
                res = (n <= 0) && (n >= d);
            end else begin
                res = 1'b0;
            end
            return res;
        end
    endfunction

endpackage

[src/swc_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the crossing test: handshakes, wall count register and table sweep.
// Depends on swc_pkg.
module swc_ctrl (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_req_type,
    input  logic [5:0]                s_entry_index,
    output logic                      m_valid,
    input  logic                      m_ready,
    input  logic                      cfg_wr_en,
    input  logic [swc_pkg::COUNT_W-1:0] cfg_wr_data,
    input  swc_pkg::swc_status_t      status,
    output swc_pkg::swc_cmd_t         cmd
);
    import swc_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   limit_reg, limit_next;
    logic [COUNT_W-1:0] wall_count_reg;
    logic               m_valid_reg, m_valid_next;
    logic [CNT_W-1:0]   limit_w;
    logic               idx_ok;

    // Counts above the table size are clamped to it.
    assign limit_w = (int'(wall_count_reg) > MAX_WALLS) ? CNT_W'(MAX_WALLS)
                                                        : CNT_W'(wall_count_reg);
    assign idx_ok  = int'(s_entry_index) < MAX_WALLS;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        limit_next   = limit_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        cmd.rd_addr  = cnt_reg[AW-1:0];
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_req_type == REQ_QUERY) begin
                        cmd.start  = 1'b1;
                        cnt_next   = '0;
                        limit_next = limit_w;
                        state_next = (limit_w == '0) ? ST_DRAIN : ST_ISSUE;
                    end else begin
                        cmd.wr_en = idx_ok;
                    end
                end
            end
            ST_ISSUE: begin
                cmd.rd_en = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if ((cnt_reg + CNT_W'(1)) == limit_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_result = 1'b1;
                    m_valid_next    = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            limit_reg      <= '0;
            m_valid_reg    <= 1'b0;
            wall_count_reg <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            limit_reg   <= limit_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                wall_count_reg <= cfg_wr_data;
            end
        end
    end

endmodule

[src/swc_dp.sv]
`timescale 1ns / 1ps
// Datapath of the crossing test: wall table memory and a four-stage
// determinant pipeline with a hit accumulator. Depends on swc_pkg.
module swc_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [5:0]                         s_entry_index,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_a_x,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_a_y,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_b_x,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_b_y,
    input  swc_pkg::swc_cmd_t                  cmd,
    output swc_pkg::swc_status_t               status,
    output logic                               m_hit
);
    import swc_pkg::*;

    logic [ENTRY_W-1:0] wall_mem [MAX_WALLS];

    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [ENTRY_W-1:0]        rd_data_reg;
    logic                      rv_reg, dv_reg, pv_reg, sv_reg;
    logic signed [DIFF_W-1:0]  ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic signed [PROD_W-1:0]  p_det0_reg, p_det1_reg, p_nl0_reg, p_nl1_reg;
    logic signed [PROD_W-1:0]  p_ng0_reg, p_ng1_reg;
    logic signed [SUM_W-1:0]   det_reg, nl_reg, ng_reg;
    logic                      acc_reg, hit_reg;
    logic signed [COORD_W-1:0] cx, cy, dx, dy;
    logic                      wall_hit;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            wall_mem[AW'(s_entry_index)] <= {s_point_b_y, s_point_b_x,
                                             s_point_a_y, s_point_a_x};
        end
        if (cmd.rd_en) begin
            rd_data_reg <= wall_mem[cmd.rd_addr];
        end
    end

    assign cx = rd_data_reg[COORD_W-1:0];
    assign cy = rd_data_reg[2*COORD_W-1:COORD_W];
    assign dx = rd_data_reg[3*COORD_W-1:2*COORD_W];
    assign dy = rd_data_reg[4*COORD_W-1:3*COORD_W];

    assign wall_hit = in_unit(nl_reg, det_reg) && in_unit(ng_reg, det_reg);

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            ax_reg <= s_point_a_x;
            ay_reg <= s_point_a_y;
            bx_reg <= s_point_b_x;
            by_reg <= s_point_b_y;
        end
        ux_reg     <= DIFF_W'(bx_reg) - DIFF_W'(ax_reg);
        uy_reg     <= DIFF_W'(by_reg) - DIFF_W'(ay_reg);
        vx_reg     <= DIFF_W'(dx) - DIFF_W'(cx);
        vy_reg     <= DIFF_W'(dy) - DIFF_W'(cy);
        wx_reg     <= DIFF_W'(dx) - DIFF_W'(ax_reg);
        wy_reg     <= DIFF_W'(dy) - DIFF_W'(ay_reg);
        p_det0_reg <= ux_reg * vy_reg;
        p_det1_reg <= vx_reg * uy_reg;
        p_nl0_reg  <= vy_reg * wx_reg;
        p_nl1_reg  <= vx_reg * wy_reg;
        p_ng0_reg  <= ux_reg * wy_reg;
        p_ng1_reg  <= uy_reg * wx_reg;
        det_reg    <= SUM_W'(p_det0_reg) - SUM_W'(p_det1_reg);
        nl_reg     <= SUM_W'(p_nl0_reg) - SUM_W'(p_nl1_reg);
        ng_reg     <= SUM_W'(p_ng0_reg) - SUM_W'(p_ng1_reg);
        if (cmd.load_result) begin
            hit_reg <= acc_reg;
        end
    end

    // Stage valids and the accumulated hit flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg  <= 1'b0;
            dv_reg  <= 1'b0;
            pv_reg  <= 1'b0;
            sv_reg  <= 1'b0;
            acc_reg <= 1'b0;
        end else begin
            rv_reg <= cmd.rd_en;
            dv_reg <= rv_reg;
            pv_reg <= dv_reg;
            sv_reg <= pv_reg;
            if (cmd.start) begin
                acc_reg <= 1'b0;
            end else if (sv_reg && wall_hit) begin
                acc_reg <= 1'b1;
            end
        end
    end

    assign status.busy = rv_reg || dv_reg || pv_reg || sv_reg;
    assign m_hit       = hit_reg;

endmodule

[src/segment_wall_collision.sv]
`timescale 1ns / 1ps
// Top level of the segment/wall crossing test: controller plus datapath.
// Depends on swc_pkg, swc_ctrl and swc_dp.
//
// Usage. The input channel (s_valid/s_ready) carries two kinds of item. A write
// item (s_req_type = 0) stores the wall from point A to point B in table slot
// s_entry_index; it is taken while idle and returns nothing. A query item
// (s_req_type = 1) carries a movement segment from A to B and returns exactly
// one result item on the m_valid/m_ready channel: m_hit is 1 when the segment
// crosses, or touches, any of the first wall_count walls. Parallel and
// zero-length segments never hit. Table slots must be written before a query
// reaches them.
//
// wall_count is set through cfg_wr_en/cfg_wr_data; the user must write it only
// while the block is idle, which the block itself does not enforce. Values above
// the table size test the whole table.
// Timing. A query sweeps the table one wall per cycle into a four-stage
// determinant pipeline. Once the pipeline has drained and the output register
// is free, the result goes valid and the input ready in the same cycle. Write
// items are taken back to back.
//
// The result sits in an output register: while the receiver stalls, the block
// still accepts writes and the next query, and that query's result waits for
// the register to free. Reset (aresetn low, synchronous) empties the pipeline,
// drops any pending result and clears wall_count; table contents are undefined.
module segment_wall_collision (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [5:0]                         s_entry_index,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_a_x,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_a_y,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_b_x,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_b_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    input  logic                               cfg_wr_en,
    input  logic [swc_pkg::COUNT_W-1:0]        cfg_wr_data
);
    import swc_pkg::*;

    swc_cmd_t    cmd;
    swc_status_t status;

    // The controller owns both handshakes and sequences the table sweep.
    swc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_entry_index (s_entry_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .status        (status),
        .cmd           (cmd)
    );

    // The datapath holds the wall table and evaluates one wall per cycle.
    swc_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_entry_index (s_entry_index),
        .s_point_a_x   (s_point_a_x),
        .s_point_a_y   (s_point_a_y),
        .s_point_b_x   (s_point_b_x),
        .s_point_b_y   (s_point_b_y),
        .cmd           (cmd),
        .status        (status),
        .m_hit         (m_hit)
    );

endmodule

[src/swc_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the segment/wall crossing test, bound to the top level.
// Depends on swc_pkg and segment_wall_collision.
module swc_port_checks (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic s_req_type,
    input logic m_valid,
    input logic m_ready,
    input logic m_hit
);
    import swc_pkg::*;

    // A stalled result item holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit))
        else $error("result item changed while stalled");

    // A query blocks the input channel while the table is swept.
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_QUERY) |=> !s_ready)
        else $error("input ready right after a query item");

    // A new result only appears at the end of a sweep.
    a_result_after_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result item appeared without a sweep");

    // A write item never produces a result.
    a_write_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_req_type == REQ_WRITE) && !m_valid |=> !m_valid)
        else $error("write item produced a result");

    // Reset drops any pending result.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind segment_wall_collision swc_port_checks u_swc_port_checks (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .s_req_type (s_req_type),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_hit      (m_hit)
);

[dv/swc_checker.sv]
`timescale 1ns / 1ps
// Checker for the segment/wall crossing test: watches both channels and the count register,
// keeps its own wall table and predicts each hit flag. Depends on swc_pkg.
module swc_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic                               s_req_type,
    input  logic [5:0]                         s_entry_index,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_a_x,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_a_y,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_b_x,
    input  logic signed [swc_pkg::COORD_W-1:0] s_point_b_y,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic                               m_hit,
    input  logic                               cfg_wr_en,
    input  logic [swc_pkg::COUNT_W-1:0]        cfg_wr_data,
    output int                                 mismatch_count,
    output int                                 hits_owed,
    output int                                 results_seen,
    output int                                 hits_seen
);
    import swc_pkg::*;

    // Exact widths: coordinate differences need one extra bit, the cross products twice
    // that, and the difference of two products one more.
    localparam int SPAN_W  = COORD_W + 1;
    localparam int CROSS_W = 2 * SPAN_W + 1;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
    } seg_t;

    seg_t               walls [MAX_WALLS];
    logic [COUNT_W-1:0] active_count;
    bit                 pending_hits [$];
    int                 err_n;
    int                 result_n;
    int                 hit_n;

    // The ratio num/den lies in [0,1] when both share a sign and |num| <= |den|.
    function automatic bit ratio_in_unit(input logic signed [CROSS_W-1:0] num,
                                         input logic signed [CROSS_W-1:0] den);
        if (den > 0) begin
            return (num >= 0) && (num <= den);
        end
        return (num <= 0) && (num >= den);
    endfunction

    function automatic bit wall_crossed(input seg_t q, input seg_t w);
        logic signed [SPAN_W-1:0]  ux, uy, vx, vy, wx, wy;
        logic signed [CROSS_W-1:0] det, t_num, s_num;
        ux    = q.bx - q.ax;
        uy    = q.by - q.ay;
        vx    = w.bx - w.ax;
        vy    = w.by - w.ay;
        wx    = w.bx - q.ax;
        wy    = w.by - q.ay;
        det   = ux * vy - vx * uy;
        t_num = vy * wx - vx * wy;
        s_num = ux * wy - uy * wx;
        if (det == 0) begin
            return 1'b0;
        end
        return ratio_in_unit(t_num, det) && ratio_in_unit(s_num, det);
    endfunction

    function automatic bit predict_hit(input seg_t q);
        int limit;
        bit found;
        limit = (active_count > MAX_WALLS) ? MAX_WALLS : int'(active_count);
        found = 1'b0;
        for (int i = 0; i < limit; i++) begin
            if (!found && wall_crossed(q, walls[i])) begin
                found = 1'b1;
            end
        end
        return found;
    endfunction

    always @(posedge aclk) begin
        bit   want;
        seg_t seg;
        if (!aresetn) begin
            pending_hits.delete();
            active_count = '0;
        end else begin
            // Results are handled before new input so that a stray result can never be
            // matched against a query accepted on the same edge.
            if (m_valid && m_ready) begin
                result_n++;
                if (m_hit === 1'b1) begin
                    hit_n++;
                end
                if (pending_hits.size() == 0) begin
                    $error("hit: result with no query waiting, actual %0b", m_hit);
                    err_n++;
                end else begin
                    want = pending_hits.pop_front();
                    if (m_hit !== want) begin
                        $error("hit mismatch: expected %0b, actual %0b", want, m_hit);
                        err_n++;
                    end
                end
            end
            if (cfg_wr_en) begin
                active_count = cfg_wr_data;
            end
            if (s_valid && s_ready) begin
                seg = '{s_point_a_x, s_point_a_y, s_point_b_x, s_point_b_y};
                if (s_req_type == REQ_WRITE) begin
                    walls[s_entry_index] = seg;
                end else begin
                    pending_hits.push_back(predict_hit(seg));
                end
            end
        end
        mismatch_count <= err_n;
        hits_owed      <= pending_hits.size();
        results_seen   <= result_n;
        hits_seen      <= hit_n;
    end

endmodule

[dv/tb_segment_wall_collision.sv]
`timescale 1ns / 1ps
// Testbench top for segment_wall_collision: clock, reset, stimulus and verdict.
// Depends on swc_pkg, the block itself and swc_checker, which does all prediction.
module tb_segment_wall_collision;

    import swc_pkg::*;

    // This covers the longest sweep, over a full table, with margin.
    localparam int SETTLE_CYCLES  = 80;
    // The longest correct stretch without a handshake is a drain plus a settle, so
    // this limit only trips on a hung block.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TARGET_ITEMS   = 1800;

    typedef struct packed {
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
    } seg_t;

    logic                      aclk          = 1'b0;
    logic                      aresetn       = 1'b0;
    logic                      s_valid       = 1'b0;
    logic                      s_req_type    = REQ_WRITE;
    logic [5:0]                s_entry_index = '0;
    logic signed [COORD_W-1:0] s_point_a_x   = '0;
    logic signed [COORD_W-1:0] s_point_a_y   = '0;
    logic signed [COORD_W-1:0] s_point_b_x   = '0;
    logic signed [COORD_W-1:0] s_point_b_y   = '0;
    logic                      m_ready       = 1'b0;
    logic                      cfg_wr_en     = 1'b0;
    logic [COUNT_W-1:0]        cfg_wr_data   = '0;
    logic                      s_ready;
    logic                      m_valid;
    logic                      m_hit;

    int mismatch_count;
    int hits_owed;
    int results_seen;
    int hits_seen;

    // Stimulus-side copy of the wall table. It only serves to aim queries at known
    // walls (endpoint touches, parallel offsets); it plays no part in checking.
    seg_t               wall_shadow [MAX_WALLS];
    logic [COUNT_W-1:0] cur_count    = '0;
    int                 burst_left   = 0;
    int                 items_sent   = 0;
    int                 queries_sent = 0;
    int                 idle_cycles  = 0;

    // Receiver stall pattern state, used only by the m_ready process.
    int stall_left = 0;
    int mode_left  = 0;
    bit calm       = 1'b0;

    always #1 aclk = ~aclk;

    segment_wall_collision i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_entry_index (s_entry_index),
        .s_point_a_x   (s_point_a_x),
        .s_point_a_y   (s_point_a_y),
        .s_point_b_x   (s_point_b_x),
        .s_point_b_y   (s_point_b_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    swc_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_entry_index  (s_entry_index),
        .s_point_a_x    (s_point_a_x),
        .s_point_a_y    (s_point_a_y),
        .s_point_b_x    (s_point_b_x),
        .s_point_b_y    (s_point_b_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hit          (m_hit),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mismatch_count (mismatch_count),
        .hits_owed      (hits_owed),
        .results_seen   (results_seen),
        .hits_seen      (hits_seen)
    );

    // The receiver alternates between calm stretches, where it always takes the result,
    // and choppy stretches with stalls of random length.
    always @(posedge aclk) begin
        if (mode_left == 0) begin
            calm      = ($urandom_range(0, 3) == 0);
            mode_left = $urandom_range(50, 400);
        end
        mode_left--;
        if (calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(1, 12);
            end
        end
    end

    // Any handshake on either channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic seg_t make_seg(input int ax, input int ay, input int bx, input int by);
        seg_t s;
        s.ax = COORD_W'(ax);
        s.ay = COORD_W'(ay);
        s.bx = COORD_W'(bx);
        s.by = COORD_W'(by);
        return s;
    endfunction

    // A signed offset in [-r, r]; the truncation keeps the two's complement value.
    function automatic logic signed [COORD_W-1:0] near(input int r);
        return COORD_W'($urandom_range(0, 2 * r) - r);
    endfunction

    function automatic logic signed [COORD_W-1:0] full_coord();
        return COORD_W'($urandom);
    endfunction

    function automatic logic signed [COORD_W-1:0] edge_coord();
        case ($urandom_range(0, 3))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            default: return 16'shffff;
        endcase
    endfunction

    // Walls mostly sit in a cluster around the origin so that queries meet them often;
    // the radius varies from one unit to 256 units, a sixteenth of the coordinate range.
    function automatic seg_t random_wall();
        seg_t s;
        int   r;
        r = 16 << $urandom_range(0, 8);
        case ($urandom_range(0, 9))
            0, 1: s = '{full_coord(), full_coord(), full_coord(), full_coord()};
            8: s = '{edge_coord(), edge_coord(), edge_coord(), edge_coord()};
            9: begin
                s.ax = near(r);
                s.ay = near(r);
                s.bx = s.ax;
                s.by = s.ay;
            end
            default: s = '{near(r), near(r), near(r), near(r)};
        endcase
        return s;
    endfunction

    function automatic seg_t random_query();
        seg_t s;
        seg_t w;
        int   r;
        int   n;
        int   pick;
        r    = 16 << $urandom_range(0, 8);
        n    = (cur_count > MAX_WALLS) ? MAX_WALLS : int'(cur_count);
        pick = $urandom_range(0, 9);
        // Aimed queries need an active wall to aim at.
        if (n == 0 && (pick == 7 || pick == 8)) begin
            pick = 2;
        end
        if (n > 0) begin
            w = wall_shadow[$urandom_range(0, n - 1)];
        end
        case (pick)
            0, 1: s = '{full_coord(), full_coord(), full_coord(), full_coord()};
            6: begin
                // Zero-length movement.
                s.ax = near(r);
                s.ay = near(r);
                s.bx = s.ax;
                s.by = s.ay;
            end
            7: begin
                // Start or end exactly on a wall endpoint: a touch that must count as a hit
                // unless the determinant is zero (parallel movement, or a zero-length segment).
                if ($urandom_range(0, 1) == 0) begin
                    s.ax = w.ax;
                    s.ay = w.ay;
                end else begin
                    s.ax = w.bx;
                    s.ay = w.by;
                end
                s.bx = s.ax + near(r);
                s.by = s.ay + near(r);
                if ($urandom_range(0, 1) == 0) begin
                    s = '{s.bx, s.by, s.ax, s.ay};
                end
            end
            8: begin
                // The wall itself shifted by a small offset: same direction, zero
                // determinant. A zero offset gives a collinear overlap.
                s.ax = near(64);
                s.ay = near(64);
                s    = '{w.ax + s.ax, w.ay + s.ay, w.bx + s.ax, w.by + s.ay};
            end
            9: s = '{edge_coord(), edge_coord(), edge_coord(), edge_coord()};
            default: s = '{near(r), near(r), near(r), near(r)};
        endcase
        return s;
    endfunction

    // Presents one item and returns at the edge where it is accepted, with valid still
    // high. A new burst starts with a random gap; roughly a third of bursts start at once.
    task automatic send_item(input logic req, input logic [5:0] idx, input seg_t seg);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_req_type    <= req;
        s_entry_index <= idx;
        s_point_a_x   <= seg.ax;
        s_point_a_y   <= seg.ay;
        s_point_b_x   <= seg.bx;
        s_point_b_y   <= seg.by;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (req == REQ_QUERY) begin
            queries_sent++;
        end else begin
            wall_shadow[idx] = seg;
        end
    endtask

    // Stops sending, waits until every query has its result and lets the block settle.
    // The extra edge before polling lets the checker count a query accepted on the
    // edge where this task is entered.
    task automatic drain_and_settle();
        s_valid    <= 1'b0;
        burst_left  = 0;
        @(posedge aclk);
        while (hits_owed != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The count register is only written while the block is idle.
    task automatic set_wall_count(input logic [COUNT_W-1:0] value);
        drain_and_settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_count  = value;
    endtask

    initial begin
        logic [COUNT_W-1:0] next_count;
        int                 phase_len;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part. Coordinates are Q12.4, so 16 is one unit.
        // With the reset count of zero no wall is tested, so even a crossing misses.
        send_item(REQ_QUERY, 6'd0, make_seg(0, -800, 0, 800));
        // A horizontal wall, a diagonal across the full range, a point-sized wall,
        // and the last table slot.
        send_item(REQ_WRITE, 6'd0, make_seg(-1600, 0, 1600, 0));
        send_item(REQ_WRITE, 6'd1, make_seg(-32768, -32768, 32767, 32767));
        send_item(REQ_WRITE, 6'd2, make_seg(500, 500, 500, 500));
        send_item(REQ_WRITE, 6'd63, make_seg(32767, -32768, -32768, 32767));

        set_wall_count(7'd1);
        send_item(REQ_QUERY, 6'd63, make_seg(0, -800, 0, 800));      // clean crossing
        send_item(REQ_QUERY, 6'd0, make_seg(-800, 160, 800, 160));   // parallel
        send_item(REQ_QUERY, 6'd0, make_seg(-800, 0, 800, 0));       // collinear overlap
        send_item(REQ_QUERY, 6'd0, make_seg(0, 0, 0, 0));            // zero length
        send_item(REQ_QUERY, 6'd0, make_seg(1600, -800, 1600, 0));   // ends on wall end
        send_item(REQ_QUERY, 6'd0, make_seg(0, 0, 0, 800));          // starts on the wall
        send_item(REQ_QUERY, 6'd0, make_seg(1601, -800, 1601, 800)); // just past the end

        set_wall_count(7'd3);
        send_item(REQ_QUERY, 6'd21, make_seg(-32768, 32767, 32767, -32768));
        send_item(REQ_QUERY, 6'd42, make_seg(500, 400, 500, 600));
        send_item(REQ_QUERY, 6'd0, make_seg(480, 500, 520, 500));

        // Fill the whole table so that any count, up to the all-ones value that the
        // block clamps to the table size, only ever reads written slots.
        for (int i = 0; i < MAX_WALLS; i++) begin
            send_item(REQ_WRITE, 6'(i), random_wall());
        end

        // Random phases: a count setting, then a mix of queries and table updates.
        // Small counts dominate so that misses stay common.
        while (items_sent < TARGET_ITEMS) begin
            case ($urandom_range(0, 7))
                0: next_count = 7'd0;
                1: next_count = 7'd1;
                2: next_count = 7'd64;
                3: next_count = 7'd127;
                4, 5: next_count = COUNT_W'($urandom_range(1, 8));
                default: next_count = COUNT_W'($urandom_range(0, 127));
            endcase
            set_wall_count(next_count);
            phase_len = $urandom_range(10, 60);
            repeat (phase_len) begin
                if ($urandom_range(0, 99) < 70) begin
                    send_item(REQ_QUERY, 6'($urandom_range(0, 63)), random_query());
                end else begin
                    send_item(REQ_WRITE, 6'($urandom_range(0, 63)), random_wall());
                end
                // Now and then the sender holds off until the block has answered all.
                if ($urandom_range(0, 199) == 0) begin
                    drain_and_settle();
                end
            end
        end

        drain_and_settle();
        $display("Sent %0d items, %0d of them queries, over wall counts from 0 to 127.",
                 items_sent, queries_sent);
        $display("Checked %0d hit flags, %0d of them set.", results_seen, hits_seen);
        if (mismatch_count == 0 && hits_owed == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[segment_wall_collision.f]
src/swc_pkg.sv
src/swc_ctrl.sv
src/swc_dp.sv
src/segment_wall_collision.sv
src/swc_checker.sv
dv/swc_checker.sv
dv/tb_segment_wall_collision.sv
